// File: sv/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned LIM_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request and clear the scan results
        logic scan;      // examine the entry at the scan index
        logic scan_last; // this scan step is the final one
        logic apply;     // perform the update decided by the scan
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

// File: sv/lfu_ctrl.sv
// Controller state machine that sequences load, scan, update and result.
`timescale 1ns / 1ps

module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Commands are decoded from the current state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_valid;
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.scan_last = (r_state == S_SCAN) && i_stat.scan_done;
        o_cmd.apply     = (r_state == S_APPLY);
    end

    // State register and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_stat.scan_done) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_ready)
        else $error("request accepted while a result is pending");
    a_apply_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> o_out_valid)
        else $error("update not followed by result");
`endif

endmodule

// File: sv/lfu_dp.sv
// Datapath: entry storage, sequential scan for match and victim, and update.
`timescale 1ns / 1ps

module lfu_dp
    import lfu_pkg::*;
#(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic [LIM_W-1:0] i_limit,
    input  logic             i_cmd_bit,
    input  logic [KEY_W-1:0] i_lookup_key,
    input  logic [VAL_W-1:0] i_write_value,
    output logic             o_hit,
    output logic [VAL_W-1:0] o_read_value,
    output logic             o_evicted,
    output logic [KEY_W-1:0] o_evicted_key
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned FW = $clog2(CAPACITY + 1);
    localparam int unsigned LW = (FW > LIM_W) ? FW : LIM_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Entry storage; only the valid bits and the fill count are reset.
    logic [CAPACITY-1:0]    r_valid;
    logic [KEY_W-1:0]       r_key   [CAPACITY];
    logic [VAL_W-1:0]       r_val   [CAPACITY];
    logic [COUNT_WIDTH-1:0] r_cnt   [CAPACITY];
    logic [IW-1:0]          r_rank  [CAPACITY];
    logic [FW-1:0]          r_fill;

    // Captured request and scan results.
    logic                   r_op;
    logic [KEY_W-1:0]       r_req_key;
    logic [VAL_W-1:0]       r_req_val;
    logic [IW-1:0]          r_idx;
    logic                   r_found;
    logic [IW-1:0]          r_hit_idx;
    logic                   r_vic_ok;
    logic [IW-1:0]          r_vic_idx;
    logic [COUNT_WIDTH-1:0] r_vic_cnt;
    logic [IW-1:0]          r_vic_rank;
    logic [KEY_W-1:0]       r_vic_key;
    logic                   r_free_ok;
    logic [IW-1:0]          r_free_idx;

    logic             r_hit;
    logic [VAL_W-1:0] r_rd;
    logic             r_ev;
    logic [KEY_W-1:0] r_evk;

    logic [LW-1:0] eff_limit;
    logic          better;
    logic          ins_evict;
    logic [IW-1:0] ins_slot;
    logic          ins_ok;
    logic [IW-1:0] ref_rank;

    assign o_stat.scan_done = (r_idx == IW'(CAPACITY - 1));

    // Effective limit is the register clamped to the capacity.
    assign eff_limit = (LW'(i_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(i_limit);

    // Victim comparison: smaller count, or equal count and older rank.
    assign better = !r_vic_ok || (r_cnt[r_idx] < r_vic_cnt) ||
                    ((r_cnt[r_idx] == r_vic_cnt) && (r_rank[r_idx] > r_vic_rank));

    assign ins_evict = (LW'(r_fill) >= eff_limit) && (r_fill != '0) && r_vic_ok;
    assign ins_slot  = ins_evict ? r_vic_idx : r_free_idx;
    assign ins_ok    = ins_evict || r_free_ok;
    assign ref_rank  = r_found ? r_rank[r_hit_idx] : r_vic_rank;

    // Scan control and request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_cmd_bit;
            r_req_key  <= i_lookup_key;
            r_req_val  <= i_write_value;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_vic_ok   <= 1'b0;
            r_free_ok  <= 1'b0;
            r_hit_idx  <= '0;
            r_vic_idx  <= '0;
            r_free_idx <= '0;
        end else if (i_cmd.scan) begin
            if (!i_cmd.scan_last) r_idx <= r_idx + IW'(1);
            if (r_valid[r_idx]) begin
                if (!r_found && r_key[r_idx] == r_req_key) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_idx;
                end
                if (better) begin
                    r_vic_ok   <= 1'b1;
                    r_vic_idx  <= r_idx;
                    r_vic_cnt  <= r_cnt[r_idx];
                    r_vic_rank <= r_rank[r_idx];
                    r_vic_key  <= r_key[r_idx];
                end
            end else if (!r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
        end
    end

    // Result fields are formed during the update step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_rd  <= MISS_VALUE;
            r_ev  <= 1'b0;
            r_evk <= '0;
        end else if (i_cmd.apply) begin
            r_hit <= r_found;
            r_rd  <= (r_op == CMD_GET && r_found) ? r_val[r_hit_idx] : MISS_VALUE;
            r_ev  <= (r_op == CMD_PUT) && (eff_limit != '0) && !r_found && ins_evict;
            r_evk <= ((r_op == CMD_PUT) && (eff_limit != '0) && !r_found && ins_evict)
                     ? r_vic_key : '0;
        end
    end

    // Entry payload and ranks, updated in parallel in one step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (r_found && (r_op == CMD_GET || eff_limit != '0)) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i] && IW'(i) != r_hit_idx && r_rank[i] < ref_rank)
                        r_rank[i] <= r_rank[i] + IW'(1);
                end
                r_rank[r_hit_idx] <= '0;
                if (r_cnt[r_hit_idx] != CNT_MAX)
                    r_cnt[r_hit_idx] <= r_cnt[r_hit_idx] + COUNT_WIDTH'(1);
                if (r_op == CMD_PUT) r_val[r_hit_idx] <= r_req_val;
            end else if (!r_found && r_op == CMD_PUT && eff_limit != '0 && ins_ok) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i] && !(ins_evict && IW'(i) == r_vic_idx)) begin
                        if (ins_evict && r_rank[i] > r_vic_rank)
                            r_rank[i] <= r_rank[i];
                        else
                            r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
                r_rank[ins_slot] <= '0;
                r_cnt[ins_slot]  <= COUNT_WIDTH'(1);
                r_key[ins_slot]  <= r_req_key;
                r_val[ins_slot]  <= r_req_val;
            end
        end
    end

    // Valid bits and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_cmd.apply && !r_found && r_op == CMD_PUT && eff_limit != '0
                     && ins_ok) begin
            r_valid[ins_slot] <= 1'b1;
            if (!ins_evict) r_fill <= r_fill + FW'(1);
        end
    end

    assign o_hit         = r_hit;
    assign o_read_value  = r_rd;
    assign o_evicted     = r_ev;
    assign o_evicted_key = r_evk;

`ifndef NO_ASSERTIONS
    a_fill_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == FW'($countones(r_valid)))
        else $error("fill count disagrees with valid bits");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_fill) <= LW'(CAPACITY))
        else $error("fill count above capacity");
    a_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ev |-> (r_evk == '0))
        else $error("evicted key without eviction");
`endif

endmodule

// File: sv/lfu_cache_lru_tiebreak_core.sv
// Top level of the LFU cache with LRU tie-break.
`timescale 1ns / 1ps
//
// Fully associative key/value store with least-frequently-used replacement,
// ties broken by least-recent use. A request (cmd, key, value) is taken on
// the input valid/ready handshake; one result (hit, read value, eviction
// flag and key) leaves on the output valid/ready handshake.
// Each request is served by a sequential scan, one entry per cycle, that
// finds the matching key, the victim and a free slot, then by an update step.
// One request is in flight at a time: no new request is taken until the
// result has been accepted and the block has returned to idle. While the
// receiver holds ready low the result stays stable and no new request is
// taken. Reset empties the store and sets the capacity limit to 16; no
// clearing pass is needed. The limit is written through i_cfg_we /
// i_cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Values above CAPACITY act as
// CAPACITY.
//
module lfu_cache_lru_tiebreak_core
    import lfu_pkg::*;
#(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIM_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [KEY_W-1:0]   i_lookup_key,
    input  logic signed [VAL_W-1:0] i_write_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic               o_evicted,
    output logic [KEY_W-1:0]   o_evicted_key
);

    logic [LIM_W-1:0] r_limit;
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [VAL_W-1:0] rd;

    // Capacity limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= LIM_W'(16);
        else if (i_cfg_we) r_limit <= i_cfg_data;
    end

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lfu_dp #(
        .CAPACITY    (CAPACITY),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_limit       (r_limit),
        .i_cmd_bit     (i_cmd),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_hit         (o_hit),
        .o_read_value  (rd),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    assign o_read_value = rd;

endmodule
